// ===== src/vcp_pkg.sv =====
package vcp_pkg;

   localparam int MAX_DEPTH  = 256;
   localparam int PIXEL_BITS = 8;
   localparam int PORT_W     = 8;
   localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W      = $clog2(MAX_DEPTH * ((2 ** PIXEL_BITS) - 1) + 1);
   localparam int STEP_W     = $clog2(SUM_W + 1);

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef enum logic [1:0] {
      MODE_MIN    = 2'd0,
      MODE_MAX    = 2'd1,
      MODE_MEAN   = 2'd2,
      MODE_MEDIAN = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_RUN
   } col_state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      shift;
      pixel_type voxel;
   } cell_ctrl_type;

endpackage

// ===== src/vcp_cell.sv =====
module vcp_cell (
   input  logic                   clock,
   input  vcp_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   free_slot,
   input  vcp_pkg::pixel_type     left_value,
   input  logic                   left_gt,
   input  vcp_pkg::pixel_type     right_value,
   output vcp_pkg::pixel_type     value,
   output logic                   gt
);

   vcp_pkg::pixel_type value_ff;
   vcp_pkg::pixel_type value_in;

   assign gt    = occupied && (value_ff > ctrl.voxel);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         // drain toward cell 0 during readout
         value_in = right_value;
      end else if (ctrl.insert && (gt || free_slot)) begin
         value_in = left_gt ? left_value : ctrl.voxel;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/vcp_divider.sv =====
module vcp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vcp_pkg::SUM_W-1:0]   dividend,
   input  logic [vcp_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output vcp_pkg::pixel_type          quotient
);

   logic [vcp_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [vcp_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [vcp_pkg::CNT_W-1:0]  div_ff, div_in;
   logic [vcp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [vcp_pkg::CNT_W:0]    trial;
   logic                       fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[vcp_pkg::SUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = vcp_pkg::STEP_W'(vcp_pkg::SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? vcp_pkg::CNT_W'(trial - {1'b0, div_ff})
                        : trial[vcp_pkg::CNT_W-1:0];
         quo_in  = {quo_ff[vcp_pkg::SUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == vcp_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[vcp_pkg::PIXEL_BITS-1:0];

endmodule

// ===== src/voxel_column_projection.sv =====
// Voxel column projection. Voxels of one (x,y) column stream in on req_ with
// req_tlast on the final one; each voxel is inserted in sorted position by a
// chain of MAX_DEPTH compare/shift cells, one request per cycle while it
// collects. After the last voxel of a column the block stops taking requests
// while it finishes: after a setup state, for minimum/maximum/median the
// chain drains toward cell 0 until the wanted entry sits there, or for the
// mean a bit-serial divider runs. The result is then loaded into the rsp_
// register once it is free; requests are accepted again from the next cycle,
// also while that result waits. Voxels past MAX_DEPTH in one column are
// dropped. csr_wr_data selects 0 min, 1 max, 2 truncated mean, 3 median;
// write it only while the block is idle.
module voxel_column_projection (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] voxel_value
   input  logic       req_tlast,   // last_in_column
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] projected_value
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   localparam int MAX_DEPTH = vcp_pkg::MAX_DEPTH;
   localparam int CNT_W     = vcp_pkg::CNT_W;
   localparam int SUM_W     = vcp_pkg::SUM_W;
   localparam int PIX_W     = vcp_pkg::PIXEL_BITS;

   vcp_pkg::mode_type      mode_ff;
   vcp_pkg::col_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       steps_ff, steps_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   vcp_pkg::pixel_type     rsp_data_ff, rsp_data_in;

   vcp_pkg::cell_ctrl_type cell_ctrl;
   vcp_pkg::pixel_type     cell_value [MAX_DEPTH];
   logic [MAX_DEPTH-1:0]   cell_gt;
   logic [MAX_DEPTH-1:0]   cell_occ;
   logic [MAX_DEPTH-1:0]   cell_slot;

   logic                   div_start;
   logic                   div_done;
   vcp_pkg::pixel_type     div_quotient;

   logic                   req_fire;
   logic                   full;
   logic                   finished;
   logic                   out_free;
   logic [CNT_W-1:0]       half;
   logic [PIX_W:0]         pair_sum;
   vcp_pkg::pixel_type     result;

   assign req_fire = req_tvalid && req_tready;
   assign full     = count_ff == CNT_W'(MAX_DEPTH);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign half     = count_ff >> 1;
   assign pair_sum = {1'b0, cell_value[0]} + {1'b0, cell_value[1 % MAX_DEPTH]};

   // ---------------- cell chain ----------------
   for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
      vcp_pkg::pixel_type left_value;
      vcp_pkg::pixel_type right_value;
      logic               left_gt;

      assign cell_occ[g]  = IDX < count_ff;
      assign cell_slot[g] = IDX == count_ff;

      if (g == 0) begin : g_head
         assign left_value = '0;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[g-1];
         assign left_gt    = cell_gt[g-1];
      end

      if (g == MAX_DEPTH - 1) begin : g_tail
         assign right_value = cell_value[g];
      end else begin : g_mid
         assign right_value = cell_value[g+1];
      end

      vcp_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .occupied    (cell_occ[g]),
         .free_slot   (cell_slot[g]),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[g]),
         .gt          (cell_gt[g])
      );
   end

   vcp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- result select ----------------
   always_comb begin
      result = cell_value[0];
      if (mode_ff == vcp_pkg::MODE_MEAN) begin
         result = div_quotient;
      end else if (mode_ff == vcp_pkg::MODE_MEDIAN && !count_ff[0]) begin
         result = pair_sum[PIX_W:1];
      end
   end

   assign finished = (mode_ff == vcp_pkg::MODE_MEAN) ? div_done : (steps_ff == '0);

   // ---------------- control ----------------
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      sum_in          = sum_ff;
      steps_in        = steps_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      div_start       = 1'b0;
      req_tready      = 1'b0;
      cell_ctrl.insert = 1'b0;
      cell_ctrl.shift  = 1'b0;
      cell_ctrl.voxel  = req_tdata[PIX_W-1:0];

      case (state_ff)
         vcp_pkg::ST_COLLECT: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (!full) begin
                  cell_ctrl.insert = 1'b1;
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(req_tdata[PIX_W-1:0]);
               end
               if (req_tlast) begin
                  state_in = vcp_pkg::ST_LOAD;
               end
            end
         end
         vcp_pkg::ST_LOAD: begin
            div_start = mode_ff == vcp_pkg::MODE_MEAN;
            case (mode_ff)
               vcp_pkg::MODE_MAX:    steps_in = count_ff - 1'b1;
               vcp_pkg::MODE_MEDIAN: steps_in = count_ff[0] ? half : half - 1'b1;
               default:              steps_in = '0;
            endcase
            state_in = vcp_pkg::ST_RUN;
         end
         vcp_pkg::ST_RUN: begin
            if (!finished) begin
               if (mode_ff != vcp_pkg::MODE_MEAN) begin
                  cell_ctrl.shift = 1'b1;
                  steps_in = steps_ff - 1'b1;
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               count_in     = '0;
               sum_in       = '0;
               state_in     = vcp_pkg::ST_COLLECT;
            end
         end
         default: begin
            state_in = vcp_pkg::ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vcp_pkg::ST_COLLECT;
         mode_ff      <= vcp_pkg::MODE_MIN;
         count_ff     <= '0;
         sum_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= vcp_pkg::mode_type'(csr_wr_data);
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_data_ff);

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DEPTH))
      else $error("voxel count beyond store depth");

   a_last_to_load: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> state_ff == vcp_pkg::ST_LOAD)
      else $error("column end did not start projection");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == vcp_pkg::ST_RUN)
      else $error("result raised outside projection");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != vcp_pkg::ST_COLLECT |-> !req_tready)
      else $error("request taken while projecting");

   a_store_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == vcp_pkg::ST_RUN && state_in == vcp_pkg::ST_COLLECT
      |=> count_ff == '0 && sum_ff == '0)
      else $error("store not cleared after column");

endmodule
